[src/mlprc_pkg.sv]
// Shared types, constants and the exponential table of the perceptron classifier.
package mlprc_pkg;

    localparam int FEAT_W     = 16;
    localparam int ACC_W      = 32;
    localparam int SAT_W      = 48;
    localparam int PROB_W     = 16;
    localparam int FEAT_FIELDS = 5;

    localparam logic [0:0] OP_WRITE    = 1'b0;
    localparam logic [0:0] OP_CLASSIFY = 1'b1;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HID_BIAS,
        ST_HID_MAC,
        ST_HID_STORE,
        ST_OUT_BIAS,
        ST_OUT_MAC,
        ST_OUT_STORE,
        ST_MAX,
        ST_EXP_MUL,
        ST_EXP_LOOK,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_EMIT
    } state_t;

    function automatic logic [16:0] pow2_frac(input logic [3:0] f);
        logic [16:0] r;
        begin
            unique case (f)
                4'd0:  r = 17'd65536;
                4'd1:  r = 17'd62757;
                4'd2:  r = 17'd60097;
                4'd3:  r = 17'd57549;
                4'd4:  r = 17'd55109;
                4'd5:  r = 17'd52773;
                4'd6:  r = 17'd50535;
                4'd7:  r = 17'd48393;
                4'd8:  r = 17'd46341;
                4'd9:  r = 17'd44376;
                4'd10: r = 17'd42495;
                4'd11: r = 17'd40693;
                4'd12: r = 17'd38968;
                4'd13: r = 17'd37316;
                4'd14: r = 17'd35734;
                default: r = 17'd34219;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        begin
            if (v > $signed({{(SAT_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}}))
                r = {1'b0, {(ACC_W-1){1'b1}}};
            else if (v < $signed({{(SAT_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}}))
                r = {1'b1, {(ACC_W-1){1'b0}}};
            else
                r = v[ACC_W-1:0];
            return r;
        end
    endfunction

endpackage

[src/mlp_relu_softmax_classifier_unit.sv]
// Top level of the two-layer perceptron classifier with softmax output.
//
// Input channel (in_valid / in_stall) carries one transaction per item. Opcode
// write stores weight_value at weight_index in the parameter memory; indexes
// beyond the store depth are dropped. Opcode classify runs the sample through
// a single shared multiply-accumulate unit: per row a bias step, a load step,
// one step per weight and a store step, for the hidden layer and then the
// output layer, then a max scan over the classes, a multiply and a lookup
// per exponential, and a divide per class on the restoring divider.
// Output channel (out_valid / out_stall) gives NUM_CLASSES transactions in
// class order, the last with last set, held through out_stall; in_stall stays
// high until the final one is taken.
// Reset clears the sequencer and the output valid; the parameter memory holds
// garbage until written.
module mlp_relu_softmax_classifier_unit
#(
    parameter int NUM_INPUTS  = 5,
    parameter int NUM_HIDDEN  = 16,
    parameter int NUM_CLASSES = 10
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [0:0]   opcode,
    input  logic [8:0]   weight_index,
    input  logic signed [15:0] weight_value,
    input  logic signed [15:0] feature_0,
    input  logic signed [15:0] feature_1,
    input  logic signed [15:0] feature_2,
    input  logic signed [15:0] feature_3,
    input  logic signed [15:0] feature_4,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [3:0]   class_index,
    output logic [15:0]  probability,
    output logic         is_predicted,
    output logic         last
);
    import mlprc_pkg::*;

    localparam int HB_BASE = NUM_INPUTS * NUM_HIDDEN;
    localparam int OW_BASE = HB_BASE + NUM_HIDDEN;
    localparam int OB_BASE = OW_BASE + NUM_CLASSES * NUM_HIDDEN;
    localparam int DEPTH   = OB_BASE + NUM_CLASSES;
    localparam int AW      = $clog2(DEPTH);
    localparam int IW      = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int HW      = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
    localparam int CW      = $clog2(NUM_CLASSES);

    state_t state_reg, state_next;

    logic signed [15:0] store [DEPTH];
    logic signed [15:0] rd_reg;
    logic [AW-1:0]      rd_addr;

    logic signed [FEAT_W-1:0] feat_reg [NUM_INPUTS];
    logic signed [ACC_W-1:0]  hid_reg  [NUM_HIDDEN];
    logic signed [ACC_W-1:0]  logit_reg [NUM_CLASSES];
    logic [15:0]              exp_reg  [NUM_CLASSES];
    logic [15:0]              prob_reg [NUM_CLASSES];

    logic [IW-1:0] i_reg, i_next;
    logic [HW-1:0] h_reg, h_next;
    logic [CW-1:0] c_reg, c_next;
    logic          fetch_reg, fetch_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] max_reg, max_next;
    logic [49:0]   u_reg;
    logic [20:0]   sum_reg, sum_next;
    logic [CW-1:0] best_reg, best_next;
    logic [15:0]   bestp_reg, bestp_next;
    logic          ov_reg;
    logic [CW-1:0] oc_reg;

    logic in_acc, out_acc;
    logic signed [47:0] prod;
    logic signed [31:0] mul_b;
    logic div_start, div_done;
    logic [31:0] div_q;
    logic [16:0] e_raw;
    logic [15:0] e_val;
    logic [32:0] d_val;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = ov_reg && !out_stall;

    // address the store in the cycle before its data is used
    always_comb
    begin
        rd_addr = '0;
        unique case (state_reg)
            ST_HID_BIAS: rd_addr = AW'(HB_BASE + int'(h_reg));
            ST_HID_MAC:  rd_addr = AW'(int'(h_reg) * NUM_INPUTS + int'(i_next));
            ST_OUT_BIAS: rd_addr = AW'(OB_BASE + int'(c_reg));
            ST_OUT_MAC:  rd_addr = AW'(OW_BASE + int'(c_reg) * NUM_HIDDEN + int'(h_next));
            default:     rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && opcode == OP_WRITE && int'(weight_index) < DEPTH)
            store[AW'(weight_index)] <= weight_value;
        rd_reg <= store[rd_addr];
    end

    always_comb
    begin
        if (state_reg == ST_HID_MAC)
            mul_b = 32'(feat_reg[i_reg]);
        else
            mul_b = hid_reg[h_reg];
    end
    assign prod = 48'(rd_reg) * 48'(mul_b);

    assign d_val = 33'(max_reg) - 33'(logit_reg[c_reg]);
    assign e_raw = (u_reg[49:24] < 26'd17) ? (pow2_frac(u_reg[23:20]) >> u_reg[28:24]) : 17'd0;
    assign e_val = e_raw[16] ? 16'hFFFF : e_raw[15:0];

    assign div_start = (state_reg == ST_DIV_START);

    mlprc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({exp_reg[c_reg], 16'd0}),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && opcode == OP_CLASSIFY) state_next = ST_HID_BIAS;
            ST_HID_BIAS:  state_next = ST_HID_MAC;
            ST_HID_MAC:
                if (!fetch_reg && int'(i_reg) == NUM_INPUTS - 1) state_next = ST_HID_STORE;
            ST_HID_STORE:
                state_next = (int'(h_reg) == NUM_HIDDEN - 1) ? ST_OUT_BIAS : ST_HID_BIAS;
            ST_OUT_BIAS:  state_next = ST_OUT_MAC;
            ST_OUT_MAC:
                if (!fetch_reg && int'(h_reg) == NUM_HIDDEN - 1) state_next = ST_OUT_STORE;
            ST_OUT_STORE:
                state_next = (int'(c_reg) == NUM_CLASSES - 1) ? ST_MAX : ST_OUT_BIAS;
            ST_MAX:
                if (int'(c_reg) == NUM_CLASSES - 1) state_next = ST_EXP_MUL;
            ST_EXP_MUL:   state_next = ST_EXP_LOOK;
            ST_EXP_LOOK:
                state_next = (int'(c_reg) == NUM_CLASSES - 1) ? ST_DIV_START : ST_EXP_MUL;
            ST_DIV_START: state_next = ST_DIV_RUN;
            ST_DIV_RUN:
                if (div_done)
                    state_next = (int'(c_reg) == NUM_CLASSES - 1) ? ST_EMIT : ST_DIV_START;
            ST_EMIT:
                if (out_acc && int'(oc_reg) == NUM_CLASSES - 1) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        i_next     = i_reg;
        h_next     = h_reg;
        c_next     = c_reg;
        fetch_next = 1'b0;
        acc_next   = acc_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        best_next  = best_reg;
        bestp_next = bestp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                h_next = '0;
                c_next = '0;
                i_next = '0;
            end
            ST_HID_BIAS:
            begin
                i_next     = '0;
                fetch_next = 1'b1;
            end
            ST_HID_MAC:
                if (fetch_reg)
                    acc_next = sat32(48'(rd_reg) <<< 12);
                else
                begin
                    acc_next = sat32(48'(acc_reg) + prod);
                    if (int'(i_reg) != NUM_INPUTS - 1) i_next = i_reg + 1'b1;
                end
            ST_HID_STORE:
            begin
                if (int'(h_reg) != NUM_HIDDEN - 1) h_next = h_reg + 1'b1;
                else h_next = '0;
            end
            ST_OUT_BIAS:
            begin
                h_next     = '0;
                fetch_next = 1'b1;
            end
            ST_OUT_MAC:
                if (fetch_reg)
                    acc_next = sat32(48'(rd_reg) <<< 12);
                else
                begin
                    acc_next = sat32(48'(acc_reg) + prod);
                    if (int'(h_reg) != NUM_HIDDEN - 1) h_next = h_reg + 1'b1;
                end
            ST_OUT_STORE:
            begin
                if (int'(c_reg) != NUM_CLASSES - 1) c_next = c_reg + 1'b1;
                else c_next = '0;
                max_next = {1'b1, {(ACC_W-1){1'b0}}};
            end
            ST_MAX:
            begin
                if (logit_reg[c_reg] > max_reg) max_next = logit_reg[c_reg];
                if (int'(c_reg) != NUM_CLASSES - 1) c_next = c_reg + 1'b1;
                else c_next = '0;
                sum_next = '0;
            end
            ST_EXP_MUL: ;
            ST_EXP_LOOK:
            begin
                sum_next = sum_reg + 21'(e_val);
                if (int'(c_reg) != NUM_CLASSES - 1) c_next = c_reg + 1'b1;
                else c_next = '0;
                best_next  = '0;
                bestp_next = '0;
            end
            ST_DIV_START: ;
            ST_DIV_RUN:
                if (div_done)
                begin
                    if (int'(c_reg) == 0 || (div_q > 32'(bestp_reg) && bestp_reg != 16'hFFFF))
                    begin
                        best_next  = c_reg;
                        bestp_next = (div_q > 32'hFFFF) ? 16'hFFFF : div_q[15:0];
                    end
                    if (int'(c_reg) != NUM_CLASSES - 1) c_next = c_reg + 1'b1;
                end
            ST_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fetch_reg <= 1'b0;
            ov_reg    <= 1'b0;
            oc_reg    <= '0;
            i_reg     <= '0;
            h_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fetch_reg <= fetch_next;
            i_reg     <= i_next;
            h_reg     <= h_next;
            c_reg     <= c_next;
            if (state_reg == ST_DIV_RUN && state_next == ST_EMIT)
            begin
                ov_reg <= 1'b1;
                oc_reg <= '0;
            end
            else if (out_acc)
            begin
                if (int'(oc_reg) == NUM_CLASSES - 1) ov_reg <= 1'b0;
                else oc_reg <= oc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        max_reg   <= max_next;
        sum_reg   <= sum_next;
        best_reg  <= best_next;
        bestp_reg <= bestp_next;
        if (in_acc)
        begin
            for (int k = 0; k < NUM_INPUTS; k++)
            begin
                unique case (k)
                    0: feat_reg[k] <= feature_0;
                    1: feat_reg[k] <= feature_1;
                    2: feat_reg[k] <= feature_2;
                    3: feat_reg[k] <= feature_3;
                    4: feat_reg[k] <= feature_4;
                    default: feat_reg[k] <= '0;
                endcase
            end
        end
        if (state_reg == ST_HID_STORE)
            hid_reg[h_reg] <= (acc_reg > 0) ? (acc_reg >>> 12) : '0;
        if (state_reg == ST_OUT_STORE)
            logit_reg[c_reg] <= acc_reg;
        if (state_reg == ST_EXP_MUL)
            u_reg <= (50'(d_val) * 50'(LOG2E_Q16)) >> 16;
        if (state_reg == ST_EXP_LOOK)
            exp_reg[c_reg] <= e_val;
        if (state_reg == ST_DIV_RUN && div_done)
            prob_reg[c_reg] <= (div_q > 32'hFFFF) ? 16'hFFFF : div_q[15:0];
    end

    assign out_valid    = ov_reg;
    assign class_index  = 4'(oc_reg);
    assign probability  = prob_reg[oc_reg];
    assign is_predicted = (oc_reg == best_reg);
    assign last         = (int'(oc_reg) == NUM_CLASSES - 1);
endmodule

[src/mlprc_divider.sv]
// Restoring radix-2 divider for the softmax normalization, one quotient bit a cycle.
module mlprc_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [20:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] quot_reg, quot_next;
    logic [21:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [20:0] dvs_reg, dvs_next;
    logic [21:0] trial;

    assign trial = {rem_reg[20:0], quot_reg[31]};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvs_next  = dvs_reg;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule
